>>> design/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// shared widths, codes and cell command type for the positional list engine
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int CNT_W     = 7;
  localparam int ST_W      = 2;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    OP_INS_POS   = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_DEL_POS   = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_LIST_FWD  = 3'd6,
    OP_LIST_BWD  = 3'd7
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INS,
    C_DEL,
    C_DN,
    C_UP
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

>>> design/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell
// one storage cell of the list ring: shifts up, down or takes a new element
// ----------------------------------------------------------------------------
module plc_cell
  import plc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] new_value,
  input  logic [DATA_W-1:0] lo_data,
  input  logic [DATA_W-1:0] hi_data,
  output logic [DATA_W-1:0] data
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      C_INS: begin
        if (MY_POS > cmd.pos) begin
          data_nxt = lo_data;
        end else if (MY_POS == cmd.pos) begin
          data_nxt = new_value;
        end
      end
      C_DEL: begin
        if (MY_POS >= cmd.pos) begin
          data_nxt = hi_data;
        end
      end
      C_DN:    data_nxt = hi_data;
      C_UP:    data_nxt = lo_data;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

>>> design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values kept in a ring of shifting cells
// ----------------------------------------------------------------------------
// Input beats carry an opcode, a position and a value on a valid/stall
// channel; result beats leave through a registered valid/stall channel.
// An insert or delete shifts the cells from its position up (not when refused
// by status) and gives one result beat (status and new count) in the cycle
// after acceptance; edits run at one per cycle unless the receiver stalls.
// A listing rotates the whole ring once, one cell per cycle unless an emitting
// step stalls, whatever the count; one element beat leaves per emitting
// step and the last carries last = 1. An empty listing gives a single beat.
// No input beat is taken while a listing runs.
// Reset clears the count, the controller and the output valid; cell
// contents are left as they are and never read before being written.
// When the receiver stalls, the result beat holds and the ring waits to emit.
// ----------------------------------------------------------------------------
module positional_list_engine
  import plc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_opcode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_element,
  output logic [ST_W-1:0]          out_status,
  output logic [CNT_W-1:0]         out_entry_total,
  output logic                     out_last
);

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SW-1:0]    STEP_END = SW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CAP      = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FWD,
    S_BWD
  } state_t;

  state_t            state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_element_r, out_element_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_total_r, out_total_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_q [DEPTH];

  logic              load_ok;
  logic              acc;
  logic [CNT_W-1:0]  ins_pos;
  logic [CNT_W-1:0]  del_pos;
  logic [CNT_W-1:0]  step_ext;
  logic              emit;

  assign load_ok  = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !load_ok;
  assign acc      = in_valid && !in_stall;
  assign step_ext = CNT_W'(step_r);

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_element_nxt = out_element_r;
    out_status_nxt  = out_status_r;
    out_total_nxt   = out_total_r;
    out_last_nxt    = out_last_r;
    cmd.op          = C_HOLD;
    cmd.pos         = in_position;
    ins_pos         = in_position;
    del_pos         = in_position;
    emit            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_valid_nxt   = 1'b1;
          out_element_nxt = '0;
          out_status_nxt  = ST_OK;
          out_last_nxt    = 1'b1;
          case (opcode_t'(in_opcode))
            OP_INS_POS, OP_INS_FRONT, OP_INS_BACK: begin
              if (opcode_t'(in_opcode) == OP_INS_FRONT) begin
                ins_pos = '0;
              end else if (opcode_t'(in_opcode) == OP_INS_BACK) begin
                ins_pos = count_r;
              end
              if (count_r >= CAP) begin
                out_status_nxt = ST_FULL;
              end else if (ins_pos > count_r) begin
                out_status_nxt = ST_RANGE;
              end else begin
                cmd.op    = C_INS;
                cmd.pos   = ins_pos;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DEL_POS, OP_DEL_FRONT, OP_DEL_BACK: begin
              if (opcode_t'(in_opcode) == OP_DEL_FRONT) begin
                del_pos = '0;
              end else if (opcode_t'(in_opcode) == OP_DEL_BACK) begin
                del_pos = count_r - 1'b1;
              end
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (del_pos >= count_r) begin
                out_status_nxt = ST_RANGE;
              end else begin
                cmd.op    = C_DEL;
                cmd.pos   = del_pos;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_LIST_FWD, OP_LIST_BWD: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                step_nxt      = '0;
                state_nxt     = (opcode_t'(in_opcode) == OP_LIST_FWD) ? S_FWD : S_BWD;
              end
            end
            default: out_status_nxt = ST_OK;
          endcase
          out_total_nxt = count_nxt;
        end
      end
      S_FWD, S_BWD: begin
        if (state_r == S_FWD) begin
          emit = step_ext < count_r;
        end else begin
          emit = step_ext >= (CAP - count_r);
        end
        if (!emit || load_ok) begin
          cmd.op = (state_r == S_FWD) ? C_DN : C_UP;
          if (emit) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ST_OK;
            out_total_nxt   = count_r;
            out_element_nxt = (state_r == S_FWD) ? cell_q[0] : cell_q[DEPTH-1];
            out_last_nxt    = (state_r == S_FWD) ? (step_ext == count_r - 1'b1)
                                                 : (step_r == STEP_END);
          end
          if (step_r == STEP_END) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_element_r <= out_element_nxt;
    out_status_r  <= out_status_nxt;
    out_total_r   <= out_total_nxt;
    out_last_r    <= out_last_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    plc_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_value (in_value),
      .lo_data   (cell_q[(i + DEPTH - 1) % DEPTH]),
      .hi_data   (cell_q[(i + 1) % DEPTH]),
      .data      (cell_q[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_element     = out_element_r;
  assign out_status      = out_status_r;
  assign out_entry_total = out_total_r;
  assign out_last        = out_last_r;

endmodule
